FILE: sv/mma_pkg.sv
// constants, widths and payload types of the multichannel moving average filter
package mma_pkg;

  localparam int CHANNELS    = 16;
  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int CHAN_W = 4;
  localparam int AVG_W  = 16;
  localparam int SMP_W  = 16;

  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WIN_IDX_W = $clog2(WINDOW);
  localparam int CHX_W     = (CH_IDX_W > CHAN_W) ? CH_IDX_W : CHAN_W;
  localparam int CMP_W     = CHX_W + 1;
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int HIST_AW   = CH_IDX_W + WIN_IDX_W;
  localparam int HIST_DEPTH = 2 ** HIST_AW;

  localparam int DIV_W     = FILL_W;
  localparam int REM_W     = DIV_W + 1;
  localparam int RADIX_B   = 4;
  localparam int DIV_ITERS = (SUM_W + RADIX_B - 1) / RADIX_B;
  localparam int PAD_W     = DIV_ITERS * RADIX_B;
  localparam int DCNT_W    = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  typedef logic [CHAN_W-1:0]      chan_t;
  typedef logic [SMP_W-1:0]       sample_t;
  typedef logic [AVG_W-1:0]       avg_t;
  typedef logic [SAMPLE_BITS-1:0] smp_int_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [FILL_W-1:0]      fill_t;
  typedef logic [WIN_IDX_W-1:0]   win_idx_t;
  typedef logic [CH_IDX_W-1:0]    ch_idx_t;
  typedef logic [DIV_W-1:0]       divisor_t;

endpackage

FILE: sv/mma_if.sv
// handshake channels for input samples and averaged results
interface mma_in_if;
  import mma_pkg::*;
  logic    valid;
  logic    ready;
  chan_t   chan;
  sample_t sample;
  modport source (output valid, output chan, output sample, input ready);
  modport sink (input valid, input chan, input sample, output ready);
endinterface

interface mma_out_if;
  import mma_pkg::*;
  logic  valid;
  logic  ready;
  chan_t out_chan;
  avg_t  average;
  modport source (output valid, output out_chan, output average, input ready);
  modport sink (input valid, input out_chan, input average, output ready);
endinterface

FILE: sv/multichannel_moving_average_top.sv
// multichannel moving average filter, top level with sequencer and state
// Usage:
//   in_ch carries a channel number and a sample as one word; out_ch returns
//   the channel and the truncated mean of that channel's last samples (up to
//   a window of WINDOW). Each accepted word yields exactly one result word.
//   Both channels use valid/ready; a word moves when both are high.
// Timing:
//   a word is accepted only while the sequencer is idle. The sequence is the
//   history read and sum update in S_READ, then DIV_ITERS iterations (5 with
//   the default widths) of the shared divider at four quotient bits per cycle,
//   the load of the output register and the return to idle to take the next
//   word. A new word is taken only after the result of the previous one has
//   been loaded into the output register.
// Reset:
//   synchronous active low reset clears every fill count and oldest pointer,
//   so every channel restarts empty; history and sums need no clearing.
// Stall:
//   the output register holds a result until taken; while it is occupied the
//   sequencer waits in S_WAIT with the new result held in the divider, and no
//   further word is accepted until the output register is free.
module multichannel_moving_average_top (
  input  logic             clk,
  input  logic             rst_n,
  mma_in_if.sink           in_ch,
  mma_out_if.source        out_ch
);
  import mma_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  chan_t      ch_r;
  smp_int_t   smp_r;
  logic       out_valid_r, out_valid_nxt;
  chan_t      out_chan_r;
  avg_t       out_avg_r;

  fill_t    fill_r [CHANNELS];
  win_idx_t ptr_r  [CHANNELS];
  sum_t     sum_r  [CHANNELS];

  logic [CHX_W-1:0] in_ext, ch_ext;
  ch_idx_t          in_idx, idx;
  logic             in_rng;
  logic             accept;
  logic             load_out, slot_free;
  fill_t            n;
  logic             full, empty;
  sum_t             new_sum, dividend;
  divisor_t         divisor;
  win_idx_t         wr_idx;
  win_idx_t         ptr_adv;
  logic             hist_we;
  logic [HIST_AW-1:0] hist_raddr, hist_waddr;
  smp_int_t         hist_rd;
  logic             div_start, div_done;
  sum_t             quotient;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign in_ext = CHX_W'(in_ch.chan);
  assign in_idx = in_ext[CH_IDX_W-1:0];
  assign ch_ext = CHX_W'(ch_r);
  assign idx    = ch_ext[CH_IDX_W-1:0];
  assign in_rng = CMP_W'(ch_ext) < CMP_W'(CHANNELS);

  assign hist_raddr = {in_idx, ptr_r[in_idx]};

  // per-channel update computed in the read cycle
  always_comb begin
    n       = fill_r[idx];
    full    = (n == FILL_W'(WINDOW));
    empty   = (n == '0);
    if (empty) begin
      new_sum = SUM_W'(smp_r);
    end else if (full) begin
      new_sum = sum_r[idx] - SUM_W'(hist_rd) + SUM_W'(smp_r);
    end else begin
      new_sum = sum_r[idx] + SUM_W'(smp_r);
    end
    if (!in_rng) begin
      dividend = SUM_W'(smp_r);
      divisor  = DIV_W'(1);
    end else if (full) begin
      dividend = new_sum;
      divisor  = DIV_W'(WINDOW);
    end else begin
      dividend = new_sum;
      divisor  = n + 1'b1;
    end
    wr_idx  = full ? ptr_r[idx] : n[WIN_IDX_W-1:0];
    ptr_adv = (ptr_r[idx] == WIN_IDX_W'(WINDOW - 1)) ? '0 : ptr_r[idx] + 1'b1;
  end

  assign hist_we    = (state_r == S_READ) && in_rng;
  assign hist_waddr = {idx, wr_idx};
  assign div_start  = (state_r == S_READ);

  mma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (smp_r),
    .raddr (hist_raddr),
    .rdata (hist_rd)
  );

  mma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (slot_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        fill_r[c] <= '0;
        ptr_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (hist_we) begin
        if (full) begin
          ptr_r[idx] <= ptr_adv;
        end else begin
          fill_r[idx] <= n + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r  <= in_ch.chan;
      smp_r <= SAMPLE_BITS'(in_ch.sample);
    end
    if (hist_we) begin
      sum_r[idx] <= new_sum;
    end
    if (load_out) begin
      out_chan_r <= ch_r;
      out_avg_r  <= AVG_W'(quotient);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_chan = out_chan_r;
  assign out_ch.average  = out_avg_r;

endmodule

FILE: sv/mma_ram.sv
// generic single write port ram with registered read
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mma_div.sv
// iterative restoring divider, several quotient bits per cycle
module mma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mma_pkg::sum_t      dividend,
  input  mma_pkg::divisor_t  divisor,
  output logic               done,
  output mma_pkg::sum_t      quotient
);
  import mma_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0]  dq_r, dq_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  divisor_t          div_r;
  logic [PAD_W-1:0]  dq_step;
  logic [REM_W-1:0]  rem_step;

  always_comb begin
    dq_step  = dq_r;
    rem_step = rem_r;
    for (int i = 0; i < RADIX_B; i++) begin
      rem_step = {rem_step[REM_W-2:0], dq_step[PAD_W-1]};
      dq_step  = {dq_step[PAD_W-2:0], 1'b0};
      if (rem_step >= {1'b0, div_r}) begin
        rem_step   = rem_step - {1'b0, div_r};
        dq_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = PAD_W'(dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      dq_nxt  = dq_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r[SUM_W-1:0];

endmodule
